// ----- rtl/pnc_pkg.sv -----
`timescale 1ns / 1ps
package pnc_pkg;

	localparam int OP_W    = 1;
	localparam int INDEX_W = 8;
	localparam int COLOR_W = 32;
	localparam int COUNT_W = 9;
	localparam int CHAN_W  = 8;
	// four squared 8-bit differences: at most 260100
	localparam int DIST_W  = 18;

	localparam logic [OP_W-1:0] OP_WRITE = 1'b0;
	localparam logic [OP_W-1:0] OP_MATCH = 1'b1;

	localparam logic [DIST_W-1:0]  DIST_LIMIT  = 18'd200000;
	localparam logic [COUNT_W-1:0] COUNT_RESET = 9'd256;

endpackage

// ----- rtl/pnc_in_if.sv -----
`timescale 1ns / 1ps
interface pnc_in_if;
	import pnc_pkg::*;

	logic               valid;
	logic               ready;
	logic [OP_W-1:0]    operation;
	logic [INDEX_W-1:0] entry_index;
	logic [COLOR_W-1:0] color_argb;

	modport source (output valid, output operation, output entry_index, output color_argb,
		input ready);
	modport sink (input valid, input operation, input entry_index, input color_argb,
		output ready);
endinterface

// ----- rtl/pnc_out_if.sv -----
`timescale 1ns / 1ps
interface pnc_out_if;
	import pnc_pkg::*;

	logic               valid;
	logic               ready;
	logic [INDEX_W-1:0] best_index;
	logic               found;

	modport source (output valid, output best_index, output found, input ready);
	modport sink (input valid, input best_index, input found, output ready);
endinterface

// ----- rtl/pnc_cfg_if.sv -----
`timescale 1ns / 1ps
interface pnc_cfg_if;
	import pnc_pkg::*;

	logic               valid;
	logic               ready;
	logic [COUNT_W-1:0] entry_count;

	modport source (output valid, output entry_count, input ready);
	modport sink (input valid, input entry_count, output ready);
endinterface

// ----- rtl/pnc_ram.sv -----
`timescale 1ns / 1ps
module pnc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;
endmodule

// ----- rtl/pnc_dist.sv -----
`timescale 1ns / 1ps
module pnc_dist #(
	parameter int TAG_W = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic [TAG_W-1:0]           in_tag,
	input  logic [pnc_pkg::COLOR_W-1:0] color_a,
	input  logic [pnc_pkg::COLOR_W-1:0] color_b,
	output logic                       out_valid,
	output logic [TAG_W-1:0]           out_tag,
	output logic [pnc_pkg::DIST_W-1:0] out_dist
);
	import pnc_pkg::*;

	localparam int NCHAN = COLOR_W / CHAN_W;
	localparam int SQ_W  = 2 * CHAN_W;

	logic [SQ_W-1:0]   sq   [NCHAN];
	logic [DIST_W-1:0] sum;
	logic              v_s2;
	logic [TAG_W-1:0]  tag_s2;
	logic [DIST_W-1:0] dist_s2;

	always_comb begin
		logic [CHAN_W-1:0] pa;
		logic [CHAN_W-1:0] pb;
		logic [CHAN_W-1:0] d;
		sum = '0;
		for (int c = 0; c < NCHAN; c++) begin
			pa    = color_a[c*CHAN_W +: CHAN_W];
			pb    = color_b[c*CHAN_W +: CHAN_W];
			d     = (pa >= pb) ? (pa - pb) : (pb - pa);
			sq[c] = d * d;
			sum   = sum + DIST_W'(sq[c]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		tag_s2  <= in_tag;
		dist_s2 <= sum;
	end

	assign out_valid = v_s2;
	assign out_tag   = tag_s2;
	assign out_dist  = dist_s2;
endmodule

// ----- rtl/palette_nearest_color_search.sv -----
// Nearest palette color search over 32-bit ARGB entries.
// cmd: one beat per item. operation write stores color_argb at entry_index
//   (an index at or above PALETTE_DEPTH is dropped) and gives no result;
//   a write leaves the block idle, so cmd stays ready.
// operation match scans entries 0..count-1 (count = entry_count clipped to
//   PALETTE_DEPTH) and returns one res beat: best_index and found. The scan
//   reads one entry per cycle through a single squared-distance unit fed by
//   the palette RAM; an exact match stops the scan early. cmd is not ready
//   during a scan.
// cfg: entry_count, user writes only while idle (not enforced); always ready.
// res is a registered output; while it stalls, cmd still takes writes and
//   the next match, whose result waits in its final state until res drains.
// Reset clears the control state and sets entry_count to 256. The palette
//   is not cleared: entries must be written before a match reads them.
`timescale 1ns / 1ps
module palette_nearest_color_search #(
	parameter int PALETTE_DEPTH = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	pnc_cfg_if.sink    cfg,
	pnc_in_if.sink     cmd,
	pnc_out_if.source  res
);
	import pnc_pkg::*;

	localparam int IDX_W = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
	localparam int CNT_W = $clog2(PALETTE_DEPTH + 1);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	state_t             state_q;
	logic [COUNT_W-1:0] entry_count_q;
	logic [CNT_W-1:0]   lim_q;
	logic [CNT_W-1:0]   issue_q;
	logic [COLOR_W-1:0] target_q;
	logic [DIST_W-1:0]  best_d_q;
	logic [IDX_W-1:0]   best_idx_q;
	logic               hit_q;
	logic               stop_q;
	logic               res_valid_q;
	logic [INDEX_W-1:0] res_index_q;
	logic               res_found_q;

	logic               v_s1;
	logic [IDX_W-1:0]   idx_s1;

	logic               cmd_fire;
	logic               wr_en;
	logic               issue;
	logic [COLOR_W-1:0] rd_data;
	logic               d_valid;
	logic [IDX_W-1:0]   d_idx;
	logic [DIST_W-1:0]  d_dist;
	logic               res_free;
	logic               res_load;

	assign cmd.ready = (state_q == ST_IDLE);
	assign cfg.ready = 1'b1;
	assign cmd_fire  = cmd.valid && cmd.ready;
	assign wr_en     = cmd_fire && (cmd.operation == OP_WRITE)
		&& ({1'b0, cmd.entry_index} < COUNT_W'(PALETTE_DEPTH));
	assign issue     = (state_q == ST_SCAN) && (issue_q < lim_q) && !stop_q;
	assign res_free  = !res_valid_q || res.ready;
	assign res_load  = (state_q == ST_DONE) && res_free;

	pnc_ram #(
		.WIDTH (COLOR_W),
		.DEPTH (PALETTE_DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (cmd.entry_index[IDX_W-1:0]),
		.wr_data (cmd.color_argb),
		.rd_en   (issue),
		.rd_addr (issue_q[IDX_W-1:0]),
		.rd_data (rd_data)
	);

	pnc_dist #(
		.TAG_W (IDX_W)
	) u_dist (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s1),
		.in_tag    (idx_s1),
		.color_a   (rd_data),
		.color_b   (target_q),
		.out_valid (d_valid),
		.out_tag   (d_idx),
		.out_dist  (d_dist)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			entry_count_q <= COUNT_RESET;
			v_s1          <= 1'b0;
			res_valid_q   <= 1'b0;
			stop_q        <= 1'b0;
			hit_q         <= 1'b0;
		end else begin
			if (cfg.valid) begin
				entry_count_q <= cfg.entry_count;
			end
			v_s1 <= issue;
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd_fire && (cmd.operation == OP_MATCH)) begin
						hit_q   <= 1'b0;
						stop_q  <= 1'b0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (d_valid && (d_dist < best_d_q)) begin
						hit_q <= 1'b1;
						if (d_dist == '0) begin
							stop_q <= 1'b1;
						end
					end
					// drained: nothing issued now and nothing in flight
					if (!issue && !v_s1 && !d_valid) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (res_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= issue_q[IDX_W-1:0];
		if (issue) begin
			issue_q <= CNT_W'(issue_q + 1'b1);
		end
		if (cmd_fire && (cmd.operation == OP_MATCH)) begin
			target_q   <= cmd.color_argb;
			issue_q    <= '0;
			best_d_q   <= DIST_LIMIT;
			best_idx_q <= '0;
			if (entry_count_q > COUNT_W'(PALETTE_DEPTH)) begin
				lim_q <= CNT_W'(PALETTE_DEPTH);
			end else begin
				lim_q <= CNT_W'(entry_count_q);
			end
		end
		if ((state_q == ST_SCAN) && d_valid && (d_dist < best_d_q)) begin
			best_d_q   <= d_dist;
			best_idx_q <= d_idx;
		end
		if (res_load) begin
			res_found_q <= hit_q;
			res_index_q <= hit_q ? INDEX_W'(best_idx_q) : '0;
		end
	end

	assign res.valid      = res_valid_q;
	assign res.best_index = res_index_q;
	assign res.found      = res_found_q;
endmodule
